// ----- rtl/ttlc_pkg.sv -----
// Types and constants shared by the keyed expiring cache table.
package ttlc_pkg;

  localparam int KEY_W   = 64;
  localparam int VALUE_W = 32;
  localparam int TIME_W  = 32;
  localparam int LIFE_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int STATUS_W   = 3;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd600;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ENABLED    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME_SECONDS = 1'd1;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_KEPT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic               func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value_handle;
    logic [TIME_W-1:0]  now_seconds;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  found_value;
  } out_t;

endpackage

// ----- rtl/ttlc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ttlc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ttl_keyed_cache_table.sv -----
// Keyed table of entries that expire after a configurable lifetime.
// The scan reads one table entry per cycle from the entry memory; a key match ends the scan
// early, an empty table skips the scan and a disabled cache skips both scan and decision.
// One request is processed at a time; a finished result waits in the output register.
// Reset (synchronous, active low) empties the table, disables caching and sets the
// lifetime to 600 seconds; entry memory contents are not cleared.
module ttl_keyed_cache_table #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ttlc_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ttlc_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ttlc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttlc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import ttlc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = KEY_BITS + VALUE_W + TIME_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic                enabled_r;
  logic [LIFE_W-1:0]   lifetime_r;
  logic [CW-1:0]       used_r, used_nxt;

  logic                func_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VALUE_W-1:0]  val_r;
  logic [TIME_W-1:0]   now_r;

  logic [CW-1:0]       issue_r, issue_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]       chk_idx_r, chk_idx_nxt;

  logic                have_exp_r, have_exp_nxt;
  logic [TIME_W-1:0]   old_age_r, old_age_nxt;
  logic [AW-1:0]       old_idx_r, old_idx_nxt;
  logic                match_r, match_nxt;
  logic                match_ok_r, match_ok_nxt;
  logic [AW-1:0]       match_idx_r, match_idx_nxt;
  logic [VALUE_W-1:0]  match_val_r, match_val_nxt;

  out_t                res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r, out_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MW-1:0]       ram_wdata;
  logic [MW-1:0]       ram_rdata;

  logic [KEY_BITS-1:0] rd_key;
  logic [VALUE_W-1:0]  rd_val;
  logic [TIME_W-1:0]   rd_stamp;
  logic [TIME_W-1:0]   age;
  logic                alive;
  logic                hit;
  logic                last;
  logic                issue_go;
  logic                in_fire;

  ttlc_ram #(
    .WIDTH(MW),
    .DEPTH(TABLE_DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(issue_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rd_key   = ram_rdata[MW-1 -: KEY_BITS];
  assign rd_val   = ram_rdata[VALUE_W+TIME_W-1 -: VALUE_W];
  assign rd_stamp = ram_rdata[TIME_W-1:0];
  assign age      = now_r - rd_stamp;
  assign alive    = age < {{(TIME_W-LIFE_W){1'b0}}, lifetime_r};
  assign hit      = (rd_key == key_r);
  assign last     = ({1'b0, chk_idx_r} == CW'(used_r - CW'(1)));
  assign issue_go = (state_r == S_SCAN) && (issue_r != used_r);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    issue_nxt     = issue_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    have_exp_nxt  = have_exp_r;
    old_age_nxt   = old_age_r;
    old_idx_nxt   = old_idx_r;
    match_nxt     = match_r;
    match_ok_nxt  = match_ok_r;
    match_idx_nxt = match_idx_r;
    match_val_nxt = match_val_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = match_idx_r;
    ram_wdata     = {key_r, val_r, now_r};

    case (state_r)
      S_IDLE: begin
        issue_nxt    = '0;
        have_exp_nxt = 1'b0;
        old_age_nxt  = '0;
        old_idx_nxt  = '0;
        match_nxt    = 1'b0;
        match_ok_nxt = 1'b0;
        if (in_fire) begin
          if (!enabled_r) begin
            res_nxt.status      = ST_DISABLED;
            res_nxt.found_value = '0;
            state_nxt           = S_DONE;
          end else if (used_r == '0) begin
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue_go) begin
          issue_nxt   = issue_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = issue_r[AW-1:0];
        end
        if (chk_vld_r) begin
          if (!alive && (!have_exp_r || age > old_age_r)) begin
            have_exp_nxt = 1'b1;
            old_age_nxt  = age;
            old_idx_nxt  = chk_idx_r;
          end
          if (hit) begin
            match_nxt     = 1'b1;
            match_ok_nxt  = alive;
            match_idx_nxt = chk_idx_r;
            match_val_nxt = rd_val;
          end
          if (hit || last) begin
            chk_vld_nxt = 1'b0;
            state_nxt   = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        res_nxt.found_value = '0;
        state_nxt           = S_DONE;
        if (func_r == FUNC_LOOKUP) begin
          if (match_r && match_ok_r) begin
            res_nxt.status      = ST_FOUND;
            res_nxt.found_value = match_val_r;
          end else begin
            res_nxt.status = ST_MISS;
          end
        end else if (match_r && match_ok_r) begin
          res_nxt.status = ST_KEPT;
        end else if (match_r) begin
          ram_we         = 1'b1;
          ram_waddr      = match_idx_r;
          res_nxt.status = ST_STORED;
        end else if (have_exp_r) begin
          ram_we         = 1'b1;
          ram_waddr      = old_idx_r;
          res_nxt.status = ST_STORED;
        end else if (used_r != CW'(TABLE_DEPTH)) begin
          ram_we         = 1'b1;
          ram_waddr      = used_r[AW-1:0];
          used_nxt       = used_r + CW'(1);
          res_nxt.status = ST_STORED;
        end else begin
          res_nxt.status = ST_FULL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      enabled_r   <= 1'b0;
      lifetime_r  <= LIFETIME_RESET;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CACHE_ENABLED:    enabled_r  <= cfg_data[0];
          CFG_LIFETIME_SECONDS: lifetime_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_data.func;
      key_r  <= in_data.key[KEY_BITS-1:0];
      val_r  <= in_data.value_handle;
      now_r  <= in_data.now_seconds;
    end
    issue_r     <= issue_nxt;
    chk_idx_r   <= chk_idx_nxt;
    have_exp_r  <= have_exp_nxt;
    old_age_r   <= old_age_nxt;
    old_idx_r   <= old_idx_nxt;
    match_r     <= match_nxt;
    match_ok_r  <= match_ok_nxt;
    match_idx_r <= match_idx_nxt;
    match_val_r <= match_val_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the keyed expiring cache table, with its own table model.
module testbench;
  import ttlc_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BITS    = 64;
  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

  localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_ZERO     = '0;
  localparam logic [KEY_W-1:0] KEY_MIXED    = 64'h0123_4567_89AB_CDEF;
  localparam logic [KEY_W-1:0] KEY_EDGES    = 64'h8000_0000_0000_0001;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CACHE_ENABLED;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Table model and its configuration.
  logic [KEY_W-1:0]   tbl_key   [TABLE_DEPTH];
  logic [VALUE_W-1:0] tbl_value [TABLE_DEPTH];
  logic [TIME_W-1:0]  tbl_stamp [TABLE_DEPTH];
  int                 tbl_used = 0;
  logic               model_enabled = 1'b0;
  logic [LIFE_W-1:0]  model_lifetime = LIFETIME_RESET;

  out_t               pending_answers[$];
  out_t               want;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 burst_left = 0;
  int unsigned        stall_mode = 0;
  int unsigned        mode_left = 0;
  logic [15:0]        stall_pattern = 16'h0001;
  logic [TIME_W-1:0]  now_clock = '0;
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];

  ttl_keyed_cache_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS(KEY_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_t make_req(input logic func, input logic [KEY_W-1:0] key,
                                   input logic [VALUE_W-1:0] value,
                                   input logic [TIME_W-1:0] now);
    in_t req;
    req.func = func;
    req.key = key;
    req.value_handle = value;
    req.now_seconds = now;
    return req;
  endfunction

  function automatic void write_entry(input int idx, input logic [KEY_W-1:0] key,
                                      input logic [VALUE_W-1:0] value,
                                      input logic [TIME_W-1:0] now);
    tbl_key[idx] = key;
    tbl_value[idx] = value;
    tbl_stamp[idx] = now;
  endfunction

  // Computes the answer to one request and applies its effect on the table.
  function automatic out_t cache_answer(input in_t req);
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] oldest_age;
    int                oldest_idx;
    int                match_idx;
    int                idx;
    bit                have_expired;
    bit                matched;
    bit                match_fresh;
    bit                fresh;
    out_t              ans;
    key = req.key & KEY_MASK;
    ans.status = ST_MISS;
    ans.found_value = '0;
    oldest_age = '0;
    oldest_idx = 0;
    match_idx = 0;
    have_expired = 1'b0;
    matched = 1'b0;
    match_fresh = 1'b0;
    for (idx = 0; idx < tbl_used && !matched; idx++) begin
      age = req.now_seconds - tbl_stamp[idx];
      fresh = age < TIME_W'(model_lifetime);
      if (!fresh && (!have_expired || age > oldest_age)) begin
        have_expired = 1'b1;
        oldest_age = age;
        oldest_idx = idx;
      end
      if (tbl_key[idx] == key) begin
        matched = 1'b1;
        match_fresh = fresh;
        match_idx = idx;
      end
    end
    if (!model_enabled) begin
      ans.status = ST_DISABLED;
    end else if (req.func == FUNC_LOOKUP) begin
      if (matched && match_fresh) begin
        ans.status = ST_FOUND;
        ans.found_value = tbl_value[match_idx];
      end
    end else if (matched && match_fresh) begin
      ans.status = ST_KEPT;
    end else if (matched) begin
      write_entry(match_idx, key, req.value_handle, req.now_seconds);
      ans.status = ST_STORED;
    end else if (have_expired) begin
      write_entry(oldest_idx, key, req.value_handle, req.now_seconds);
      ans.status = ST_STORED;
    end else if (tbl_used < TABLE_DEPTH) begin
      write_entry(tbl_used, key, req.value_handle, req.now_seconds);
      tbl_used++;
      ans.status = ST_STORED;
    end else begin
      ans.status = ST_FULL;
    end
    return ans;
  endfunction

  task automatic flag_mismatch(input string what, input out_t exp_word, input out_t got_word);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at cycle %0d, %s: expected status %0d value %h, got status %0d value %h",
               cycle_count, what, exp_word.status, exp_word.found_value,
               got_word.status, got_word.found_value);
  endtask

  // Result checking and the receiver's stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch("unexpected word", '0, out_data);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.status !== want.status)
          flag_mismatch("status", want, out_data);
        if (out_data.found_value !== want.found_value)
          flag_mismatch("found_value", want, out_data);
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
      stall_pattern = 16'($urandom) | 16'h0001;
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: begin
        out_ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_request(input in_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_answers.push_back(cache_answer(req));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic enable, input logic [LIFE_W-1:0] life);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CACHE_ENABLED;
    cfg_data <= {15'($urandom), enable};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_enabled = enable;
    cfg_index <= CFG_LIFETIME_SECONDS;
    cfg_data <= life;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_lifetime = life;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_disabled_requests();
    send_request(make_req(FUNC_LOOKUP, KEY_ALL_ONES, '0, '0));
    send_request(make_req(FUNC_INSERT, KEY_ZERO, '1, '1));
  endtask

  task automatic test_lookup_insert();
    set_config(1'b1, 16'd600);
    send_request(make_req(FUNC_LOOKUP, KEY_ALL_ONES, '0, 32'd100));
    send_request(make_req(FUNC_INSERT, KEY_ALL_ONES, '1, 32'd100));
    send_request(make_req(FUNC_INSERT, KEY_ALL_ONES, 32'd5, 32'd699));
    send_request(make_req(FUNC_LOOKUP, KEY_ALL_ONES, '0, 32'd699));
    send_request(make_req(FUNC_LOOKUP, KEY_ALL_ONES, '0, 32'd700));
    send_request(make_req(FUNC_INSERT, KEY_ZERO, '0, 32'd701));
    send_request(make_req(FUNC_INSERT, KEY_ALL_ONES, 32'd7, 32'd701));
    send_request(make_req(FUNC_INSERT, KEY_MIXED, 32'd8, 32'd701));
    // All three entries share one stamp, so the lowest index is replaced.
    send_request(make_req(FUNC_INSERT, KEY_EDGES, 32'd9, 32'd1400));
    send_request(make_req(FUNC_INSERT, KEY_ALL_ONES, 32'd10, 32'd1401));
    send_request(make_req(FUNC_LOOKUP, KEY_MIXED, '0, 32'd1401));
    send_request(make_req(FUNC_LOOKUP, KEY_ALL_ONES, '0, 32'd1401));
    send_request(make_req(FUNC_INSERT, KEY_MIXED, 32'd13, 32'hFFFF_FFFF));
    send_request(make_req(FUNC_LOOKUP, KEY_MIXED, '0, 32'd5));
  endtask

  task automatic test_lifetime_extremes();
    set_config(1'b1, 16'd0);
    send_request(make_req(FUNC_LOOKUP, KEY_MIXED, '0, 32'd5));
    send_request(make_req(FUNC_INSERT, KEY_MIXED, 32'd15, 32'd5));
    set_config(1'b1, 16'd1);
    send_request(make_req(FUNC_LOOKUP, KEY_MIXED, '0, 32'd5));
    send_request(make_req(FUNC_LOOKUP, KEY_MIXED, '0, 32'd6));
    set_config(1'b1, 16'hFFFF);
    send_request(make_req(FUNC_LOOKUP, KEY_MIXED, '0, 32'd65539));
    send_request(make_req(FUNC_INSERT, KEY_MIXED, 32'd16, 32'd65540));
    set_config(1'b0, 16'hFFFF);
    send_request(make_req(FUNC_LOOKUP, KEY_MIXED, '0, 32'd65540));
    set_config(1'b1, 16'hFFFF);
    send_request(make_req(FUNC_LOOKUP, KEY_MIXED, '0, 32'd65540));
    now_clock = 32'd65540;
  endtask

  task automatic run_random_phase(input int count);
    in_t req;
    int  life;
    int  idx;
    life = int'(model_lifetime);
    for (idx = 0; idx < count; idx++) begin
      if (idx == count / 2)
        drain_results();
      req.func = $urandom_range(0, 1) ? FUNC_INSERT : FUNC_LOOKUP;
      if ($urandom_range(0, 99) < 85)
        req.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        req.key = {$urandom, $urandom};
      req.value_handle = $urandom;
      case ($urandom_range(0, 19))
        0: now_clock = $urandom;
        1, 2: now_clock += $urandom_range(life / 2, 2 * life);
        default: now_clock += $urandom_range(0, life / 8 + 1);
      endcase
      req.now_seconds = now_clock;
      send_request(req);
    end
  endtask

  task automatic test_random_traffic();
    int idx;
    for (idx = 0; idx < POOL_SIZE; idx++)
      key_pool[idx] = {$urandom, $urandom};
    set_config(1'b1, 16'd30);
    run_random_phase(160);
    set_config(1'b1, 16'd1);
    run_random_phase(100);
    set_config(1'b1, 16'hFFFF);
    run_random_phase(120);
    set_config(1'b0, 16'd300);
    run_random_phase(30);
    set_config(1'b1, 16'($urandom_range(2, 2000)));
    run_random_phase(170);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_requests();
    test_lookup_insert();
    test_lifetime_extremes();
    test_random_traffic();
    drain_results();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ttlc_pkg.sv
rtl/ttlc_ram.sv
rtl/ttl_keyed_cache_table.sv
tb/sv/testbench.sv
